// ===== rtl/atpr_pkg.sv =====
// Shared constants, control types and the arctangent table for the tilt core.
package atpr_pkg;

    localparam int ROLL_GUARD  = 30;
    localparam int NORM_W      = 62;
    localparam int NORM_STEPS  = 5;
    localparam int ROOT_STEPS  = 31;
    localparam int ROOT_W      = 31;
    localparam int PREP_DEPTH  = 2 + NORM_STEPS + ROOT_STEPS;
    localparam int ANG_W       = 26;
    localparam int ATAN_LEN    = 24;
    localparam int ROUND_SHIFT = 9;
    localparam int RND_W       = ANG_W - ROUND_SHIFT;
    localparam int PITCH_W     = 15;
    localparam int ROLL_W      = 16;

    localparam logic signed [ANG_W-1:0] DEG180     = ANG_W'(180 * 65536);
    localparam logic signed [ANG_W-1:0] ROUND_BIAS = ANG_W'(256);
    localparam logic signed [RND_W-1:0] PITCH_MAX  = RND_W'(11520);
    localparam logic signed [RND_W-1:0] ROLL_MAX   = RND_W'(23040);

    typedef enum logic [1:0] {
        PC_CORDIC,
        PC_ZERO,
        PC_POS,
        PC_NEG
    } pitch_case_t;

    typedef enum logic [1:0] {
        RC_PLAIN,
        RC_ZERO,
        RC_ADD180,
        RC_SUB180
    } roll_case_t;

    typedef struct packed {
        logic        valid;
        pitch_case_t pcase;
        roll_case_t  rcase;
    } atpr_ctl_t;

    // atan(2^-idx) in degrees, scaled by 2^16
    function automatic logic signed [ANG_W-1:0] atan_deg(input int idx);
        logic signed [ANG_W-1:0] t;
        case (idx)
            0:       t = ANG_W'(2949120);
            1:       t = ANG_W'(1740967);
            2:       t = ANG_W'(919879);
            3:       t = ANG_W'(466945);
            4:       t = ANG_W'(234379);
            5:       t = ANG_W'(117304);
            6:       t = ANG_W'(58666);
            7:       t = ANG_W'(29335);
            8:       t = ANG_W'(14668);
            9:       t = ANG_W'(7334);
            10:      t = ANG_W'(3667);
            11:      t = ANG_W'(1833);
            12:      t = ANG_W'(917);
            13:      t = ANG_W'(458);
            14:      t = ANG_W'(229);
            15:      t = ANG_W'(115);
            16:      t = ANG_W'(57);
            17:      t = ANG_W'(29);
            18:      t = ANG_W'(14);
            19:      t = ANG_W'(7);
            20:      t = ANG_W'(4);
            21:      t = ANG_W'(2);
            22:      t = ANG_W'(1);
            default: t = '0;
        endcase
        return t;
    endfunction

endpackage

// ===== rtl/atpr_prep.sv =====
// Operand preparation: squares, normalization and pipelined square root.
module atpr_prep #(
    parameter int SAMPLE_BITS = 16,
    parameter int DATA_W      = 48
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic signed [SAMPLE_BITS-1:0] x,
    input  logic signed [SAMPLE_BITS-1:0] y,
    input  logic signed [SAMPLE_BITS-1:0] z,
    output atpr_pkg::atpr_ctl_t           ctl_out,
    output logic signed [DATA_W-1:0]      roll_x,
    output logic signed [DATA_W-1:0]      roll_y,
    output logic signed [DATA_W-1:0]      pitch_x,
    output logic signed [DATA_W-1:0]      pitch_y
);
    import atpr_pkg::*;

    localparam int SB   = SAMPLE_BITS;
    localparam int SQ_W = 2 * SB - 1;

    // first stage
    logic signed [2*SB-1:0] prod_y, prod_z;
    logic signed [SB:0]     sx, sy, sz;
    logic [SQ_W-1:0]        yy_reg, zz_reg;
    logic signed [SB:0]     nx1_next, nx1_reg;
    logic signed [SB:0]     rx_next, ry_next;
    atpr_ctl_t              ctl_next;

    // second stage
    logic [NORM_W-1:0]      s2_reg;
    logic signed [SB:0]     nx2_reg;

    // side chain for roll operands and control
    logic signed [SB:0]     rx_reg [PREP_DEPTH];
    logic signed [SB:0]     ry_reg [PREP_DEPTH];
    atpr_ctl_t              ctl_reg [PREP_DEPTH];

    // normalization
    logic [NORM_W-1:0]        ns_cur  [NORM_STEPS];
    logic [NORM_W-1:0]        ns_next [NORM_STEPS];
    logic [NORM_W-1:0]        ns_reg  [NORM_STEPS];
    logic signed [DATA_W-1:0] xs_cur  [NORM_STEPS];
    logic signed [DATA_W-1:0] xs_next [NORM_STEPS];
    logic signed [DATA_W-1:0] xs_reg  [NORM_STEPS];

    // square root
    logic [NORM_W-1:0]        rem_cur   [ROOT_STEPS];
    logic [NORM_W-1:0]        rem_next  [ROOT_STEPS];
    logic [NORM_W-1:0]        rem_reg   [ROOT_STEPS];
    logic [NORM_W-1:0]        root_cur  [ROOT_STEPS];
    logic [NORM_W-1:0]        root_next [ROOT_STEPS];
    logic [NORM_W-1:0]        root_reg  [ROOT_STEPS];
    logic signed [DATA_W-1:0] xd_cur    [ROOT_STEPS];
    logic signed [DATA_W-1:0] xd_reg    [ROOT_STEPS];

    always_comb
    begin
        sx       = (SB+1)'(x);
        sy       = (SB+1)'(y);
        sz       = (SB+1)'(z);
        prod_y   = y * y;
        prod_z   = z * z;
        nx1_next = -sx;
        // negate the roll vector for z below zero
        rx_next  = z[SB-1] ? -sz : sz;
        ry_next  = z[SB-1] ? -sy : sy;
        ctl_next.valid = in_valid;
        if (y == '0 && z == '0)
        begin
            ctl_next.rcase = RC_ZERO;
            if (x == '0)
                ctl_next.pcase = PC_ZERO;
            else if (x[SB-1])
                ctl_next.pcase = PC_POS;
            else
                ctl_next.pcase = PC_NEG;
        end
        else
        begin
            ctl_next.pcase = PC_CORDIC;
            if (!z[SB-1])
                ctl_next.rcase = RC_PLAIN;
            else if (y[SB-1])
                ctl_next.rcase = RC_SUB180;
            else
                ctl_next.rcase = RC_ADD180;
        end
    end

    // normalize: shift s left by pairs while it stays below 2^62, x along by singles
    always_comb
    begin
        int p;
        ns_cur[0] = s2_reg;
        xs_cur[0] = DATA_W'(nx2_reg);
        for (int n = 1; n < NORM_STEPS; n++)
        begin
            ns_cur[n] = ns_reg[n-1];
            xs_cur[n] = xs_reg[n-1];
        end
        for (int n = 0; n < NORM_STEPS; n++)
        begin
            p = 1 << (NORM_STEPS - 1 - n);
            if ((ns_cur[n] >> (NORM_W - 2 * p)) == '0)
            begin
                ns_next[n] = ns_cur[n] << (2 * p);
                xs_next[n] = xs_cur[n] <<< p;
            end
            else
            begin
                ns_next[n] = ns_cur[n];
                xs_next[n] = xs_cur[n];
            end
        end
    end

    // one result bit per stage, trial bit weight 2^60 down to 2^0, result bits 2^30 down to 2^0
    always_comb
    begin
        logic [NORM_W-1:0] one_bit;
        logic [NORM_W-1:0] trial;
        rem_cur[0]  = ns_reg[NORM_STEPS-1];
        root_cur[0] = '0;
        xd_cur[0]   = xs_reg[NORM_STEPS-1];
        for (int j = 1; j < ROOT_STEPS; j++)
        begin
            rem_cur[j]  = rem_reg[j-1];
            root_cur[j] = root_reg[j-1];
            xd_cur[j]   = xd_reg[j-1];
        end
        for (int j = 0; j < ROOT_STEPS; j++)
        begin
            one_bit = NORM_W'(1) << (NORM_W - 2 - 2 * j);
            trial   = root_cur[j] + one_bit;
            if (rem_cur[j] >= trial)
            begin
                rem_next[j]  = rem_cur[j] - trial;
                root_next[j] = (root_cur[j] >> 1) + one_bit;
            end
            else
            begin
                rem_next[j]  = rem_cur[j];
                root_next[j] = root_cur[j] >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int d = 0; d < PREP_DEPTH; d++)
                ctl_reg[d] <= '0;
        end
        else
        begin
            ctl_reg[0] <= ctl_next;
            for (int d = 1; d < PREP_DEPTH; d++)
                ctl_reg[d] <= ctl_reg[d-1];
        end
    end

    always_ff @(posedge clk)
    begin
        yy_reg  <= prod_y[SQ_W-1:0];
        zz_reg  <= prod_z[SQ_W-1:0];
        nx1_reg <= nx1_next;
        s2_reg  <= NORM_W'(yy_reg) + NORM_W'(zz_reg);
        nx2_reg <= nx1_reg;
        rx_reg[0] <= rx_next;
        ry_reg[0] <= ry_next;
        for (int d = 1; d < PREP_DEPTH; d++)
        begin
            rx_reg[d] <= rx_reg[d-1];
            ry_reg[d] <= ry_reg[d-1];
        end
        for (int n = 0; n < NORM_STEPS; n++)
        begin
            ns_reg[n] <= ns_next[n];
            xs_reg[n] <= xs_next[n];
        end
        for (int j = 0; j < ROOT_STEPS; j++)
        begin
            rem_reg[j]  <= rem_next[j];
            root_reg[j] <= root_next[j];
            xd_reg[j]   <= xd_cur[j];
        end
    end

    assign ctl_out = ctl_reg[PREP_DEPTH-1];
    assign roll_x  = DATA_W'(rx_reg[PREP_DEPTH-1]) <<< ROLL_GUARD;
    assign roll_y  = DATA_W'(ry_reg[PREP_DEPTH-1]) <<< ROLL_GUARD;
    assign pitch_x = DATA_W'(root_reg[ROOT_STEPS-1][ROOT_W-1:0]);
    assign pitch_y = xd_reg[ROOT_STEPS-1];

endmodule

// ===== rtl/atpr_cordic.sv =====
// Two-lane pipelined vectoring CORDIC, one rotation per stage.
module atpr_cordic #(
    parameter int DATA_W = 48,
    parameter int STAGES = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  atpr_pkg::atpr_ctl_t             ctl_in,
    input  logic signed [DATA_W-1:0]        roll_x,
    input  logic signed [DATA_W-1:0]        roll_y,
    input  logic signed [DATA_W-1:0]        pitch_x,
    input  logic signed [DATA_W-1:0]        pitch_y,
    output atpr_pkg::atpr_ctl_t             ctl_out,
    output logic signed [atpr_pkg::ANG_W-1:0] roll_ang,
    output logic signed [atpr_pkg::ANG_W-1:0] pitch_ang
);
    import atpr_pkg::*;

    logic signed [DATA_W-1:0] rx_cur [STAGES], rx_next [STAGES], rx_reg [STAGES];
    logic signed [DATA_W-1:0] ry_cur [STAGES], ry_next [STAGES], ry_reg [STAGES];
    logic signed [ANG_W-1:0]  ra_cur [STAGES], ra_next [STAGES], ra_reg [STAGES];
    logic signed [DATA_W-1:0] px_cur [STAGES], px_next [STAGES], px_reg [STAGES];
    logic signed [DATA_W-1:0] py_cur [STAGES], py_next [STAGES], py_reg [STAGES];
    logic signed [ANG_W-1:0]  pa_cur [STAGES], pa_next [STAGES], pa_reg [STAGES];
    atpr_ctl_t                ctl_reg [STAGES];

    always_comb
    begin
        logic signed [ANG_W-1:0] t;
        rx_cur[0] = roll_x;
        ry_cur[0] = roll_y;
        ra_cur[0] = '0;
        px_cur[0] = pitch_x;
        py_cur[0] = pitch_y;
        pa_cur[0] = '0;
        for (int i = 1; i < STAGES; i++)
        begin
            rx_cur[i] = rx_reg[i-1];
            ry_cur[i] = ry_reg[i-1];
            ra_cur[i] = ra_reg[i-1];
            px_cur[i] = px_reg[i-1];
            py_cur[i] = py_reg[i-1];
            pa_cur[i] = pa_reg[i-1];
        end
        for (int i = 0; i < STAGES; i++)
        begin
            t = atan_deg(i);
            // rotate toward the x axis; y sign picks the direction
            if (!ry_cur[i][DATA_W-1])
            begin
                rx_next[i] = rx_cur[i] + (ry_cur[i] >>> i);
                ry_next[i] = ry_cur[i] - (rx_cur[i] >>> i);
                ra_next[i] = ra_cur[i] + t;
            end
            else
            begin
                rx_next[i] = rx_cur[i] - (ry_cur[i] >>> i);
                ry_next[i] = ry_cur[i] + (rx_cur[i] >>> i);
                ra_next[i] = ra_cur[i] - t;
            end
            if (!py_cur[i][DATA_W-1])
            begin
                px_next[i] = px_cur[i] + (py_cur[i] >>> i);
                py_next[i] = py_cur[i] - (px_cur[i] >>> i);
                pa_next[i] = pa_cur[i] + t;
            end
            else
            begin
                px_next[i] = px_cur[i] - (py_cur[i] >>> i);
                py_next[i] = py_cur[i] + (px_cur[i] >>> i);
                pa_next[i] = pa_cur[i] - t;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STAGES; i++)
                ctl_reg[i] <= '0;
        end
        else
        begin
            ctl_reg[0] <= ctl_in;
            for (int i = 1; i < STAGES; i++)
                ctl_reg[i] <= ctl_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < STAGES; i++)
        begin
            rx_reg[i] <= rx_next[i];
            ry_reg[i] <= ry_next[i];
            ra_reg[i] <= ra_next[i];
            px_reg[i] <= px_next[i];
            py_reg[i] <= py_next[i];
            pa_reg[i] <= pa_next[i];
        end
    end

    assign ctl_out   = ctl_reg[STAGES-1];
    assign roll_ang  = ra_reg[STAGES-1];
    assign pitch_ang = pa_reg[STAGES-1];

endmodule

// ===== rtl/accel_tilt_pitch_roll_core.sv =====
// Top level of the accelerometer pitch and roll core.
//
// One request carries a signed three-axis sample on accel_x, accel_y and
// accel_z. A request is taken at a rising edge where start is high and busy
// is low. busy is high only while rst_n is low and until the next rising
// edge after its release; after that a new request may be issued in every cycle.
//
// Each request yields one result: pitch_angle and roll_angle, signed, in
// 1/128 degree, shown for one cycle with done high. Results leave in
// request order. The pitch path runs through registers for the squares and
// their sum, five normalization stages, 31 square-root stages (one result
// bit each), one stage per CORDIC rotation and one output stage for
// rounding and saturation. The roll operands travel alongside and share
// the CORDIC stages.
//
// Reset empties the pipeline and drops any request in flight. The receiver
// cannot hold results off; done must be taken when shown.
module accel_tilt_pitch_roll_core #(
    parameter int SAMPLE_BITS   = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [SAMPLE_BITS-1:0]       accel_x,
    input  logic signed [SAMPLE_BITS-1:0]       accel_y,
    input  logic signed [SAMPLE_BITS-1:0]       accel_z,
    output logic                                done,
    output logic signed [atpr_pkg::PITCH_W-1:0] pitch_angle,
    output logic signed [atpr_pkg::ROLL_W-1:0]  roll_angle
);
    import atpr_pkg::*;

    localparam int DATA_W    = SAMPLE_BITS + ROLL_GUARD + 2;
    localparam int LAT_CHECK = CORDIC_STAGES + PREP_DEPTH + 1;

    logic                     busy_reg;
    logic                     accept;
    atpr_ctl_t                prep_ctl, cord_ctl;
    logic signed [DATA_W-1:0] roll_x, roll_y, pitch_x, pitch_y;
    logic signed [ANG_W-1:0]  roll_ang, pitch_ang;

    logic signed [ANG_W-1:0]   roll_off, roll_sum, pitch_sum;
    logic signed [RND_W-1:0]   roll_rnd, pitch_rnd, roll_sat, pitch_sat;
    logic                      done_reg;
    logic signed [PITCH_W-1:0] pitch_angle_next, pitch_angle_reg;
    logic signed [ROLL_W-1:0]  roll_angle_next, roll_angle_reg;

    assign accept = start && !busy_reg;

    atpr_prep #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .DATA_W      (DATA_W)
    ) u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (accept),
        .x        (accel_x),
        .y        (accel_y),
        .z        (accel_z),
        .ctl_out  (prep_ctl),
        .roll_x   (roll_x),
        .roll_y   (roll_y),
        .pitch_x  (pitch_x),
        .pitch_y  (pitch_y)
    );

    atpr_cordic #(
        .DATA_W (DATA_W),
        .STAGES (CORDIC_STAGES)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl_in    (prep_ctl),
        .roll_x    (roll_x),
        .roll_y    (roll_y),
        .pitch_x   (pitch_x),
        .pitch_y   (pitch_y),
        .ctl_out   (cord_ctl),
        .roll_ang  (roll_ang),
        .pitch_ang (pitch_ang)
    );

    // add the half-turn offset, round half up to 1/128 degree, clamp
    always_comb
    begin
        case (cord_ctl.rcase)
            RC_ADD180: roll_off = DEG180;
            RC_SUB180: roll_off = -DEG180;
            default:   roll_off = '0;
        endcase
        roll_sum  = roll_ang + roll_off + ROUND_BIAS;
        pitch_sum = pitch_ang + ROUND_BIAS;
        roll_rnd  = roll_sum[ANG_W-1:ROUND_SHIFT];
        pitch_rnd = pitch_sum[ANG_W-1:ROUND_SHIFT];

        if (roll_rnd > ROLL_MAX)
            roll_sat = ROLL_MAX;
        else if (roll_rnd < -ROLL_MAX)
            roll_sat = -ROLL_MAX;
        else
            roll_sat = roll_rnd;

        if (pitch_rnd > PITCH_MAX)
            pitch_sat = PITCH_MAX;
        else if (pitch_rnd < -PITCH_MAX)
            pitch_sat = -PITCH_MAX;
        else
            pitch_sat = pitch_rnd;

        case (cord_ctl.rcase)
            RC_ZERO: roll_angle_next = '0;
            default: roll_angle_next = roll_sat[ROLL_W-1:0];
        endcase

        case (cord_ctl.pcase)
            PC_ZERO: pitch_angle_next = '0;
            PC_POS:  pitch_angle_next = PITCH_MAX[PITCH_W-1:0];
            PC_NEG:  pitch_angle_next = PITCH_W'(-PITCH_MAX);
            default: pitch_angle_next = pitch_sat[PITCH_W-1:0];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= 1'b0;
            done_reg <= cord_ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        pitch_angle_reg <= pitch_angle_next;
        roll_angle_reg  <= roll_angle_next;
    end

    assign busy        = busy_reg;
    assign done        = done_reg;
    assign pitch_angle = pitch_angle_reg;
    assign roll_angle  = roll_angle_reg;

    a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT_CHECK done)
        else $error("request did not produce a result at the fixed latency");

    a_no_spurious_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT_CHECK))
        else $error("result strobe without a matching request");

    a_pitch_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (pitch_angle <= PITCH_MAX && pitch_angle >= -PITCH_MAX))
        else $error("pitch outside +-90 degrees");

    a_roll_level_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && accel_y == '0 && accel_z == '0)
        |-> ##LAT_CHECK (roll_angle == '0))
        else $error("roll not zero for a sample with y and z both zero");

endmodule
